// ===== src/sv48ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// sv48ptw_pkg
// Types, codes and helpers shared by the Sv48 page-table walker.
// ----------------------------------------------------------------------------
package sv48ptw_pkg;

   localparam int TagWidth   = 8;
   localparam int PpnWidth   = 44;
   localparam int VaWidth    = 48;
   localparam int PaWidth    = 56;
   localparam int VpnBits    = 9;
   localparam int OffsetBits = 12;

   // operation codes
   localparam logic [1:0] OP_START      = 2'd0;
   localparam logic [1:0] OP_PTE_DATA   = 2'd1;
   localparam logic [1:0] OP_FETCH_FAIL = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_PTE_READ = 2'd0;
   localparam logic [1:0] KIND_DONE     = 2'd1;
   localparam logic [1:0] KIND_REJECT   = 2'd2;

   // fault codes
   localparam logic [2:0] FAULT_NONE       = 3'd0;
   localparam logic [2:0] FAULT_INVALID    = 3'd1;
   localparam logic [2:0] FAULT_PERMISSION = 3'd2;
   localparam logic [2:0] FAULT_MISALIGNED = 3'd3;
   localparam logic [2:0] FAULT_ACCESSED   = 3'd4;
   localparam logic [2:0] FAULT_DIRTY      = 3'd5;
   localparam logic [2:0] FAULT_ACCESS     = 3'd6;

   localparam logic [1:0] LEVEL_ROOT = 2'd3;

   // held rights bits
   localparam int RightRead  = 0;
   localparam int RightWrite = 1;
   localparam int RightExec  = 2;
   localparam int RightStore = 3;

   typedef struct packed {
      logic [1:0]          operation;
      logic [VaWidth-1:0]  virt_addr;
      logic                need_read;
      logic                need_write;
      logic                need_exec;
      logic                store_access;
      logic [TagWidth-1:0] request_tag;
      logic [63:0]         pte_word;
   } req_type;

   typedef struct packed {
      logic [1:0]          result_kind;
      logic [PaWidth-1:0]  pte_read_addr;
      logic [TagWidth-1:0] done_tag;
      logic [2:0]          fault_code;
      logic [PaWidth-1:0]  phys_addr;
   } rsp_type;

   typedef struct packed {
      logic                busy;
      logic [1:0]          level;
      logic [PpnWidth-1:0] base_ppn;
      logic [VaWidth-1:0]  vaddr;
      logic [3:0]          rights;
      logic [TagWidth-1:0] tag;
   } walk_type;

   function automatic logic [PaWidth-1:0] pte_addr(input logic [PpnWidth-1:0] base,
                                                   input logic [VaWidth-1:0]  va,
                                                   input logic [1:0]          level);
      logic [VpnBits-1:0] vpn;
      case (level)
         2'd3:    vpn = va[47:39];
         2'd2:    vpn = va[38:30];
         2'd1:    vpn = va[29:21];
         default: vpn = va[20:12];
      endcase
      return {base, vpn, 3'b000};
   endfunction

   // low PPN bits that a superpage at this level must leave zero
   function automatic logic [PpnWidth-1:0] super_mask(input logic [1:0] level);
      logic [PpnWidth-1:0] m;
      case (level)
         2'd3:    m = {{(PpnWidth-27){1'b0}}, {27{1'b1}}};
         2'd2:    m = {{(PpnWidth-18){1'b0}}, {18{1'b1}}};
         2'd1:    m = {{(PpnWidth-9){1'b0}}, {9{1'b1}}};
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

// ===== src/sv48ptw_step.sv =====
// ----------------------------------------------------------------------------
// sv48ptw_step
// One walk step: decodes a beat against the walk state, checks the PTE and
// forms the result beat and the next walk state.
// ----------------------------------------------------------------------------
module sv48ptw_step (
   input  sv48ptw_pkg::req_type                      req,
   input  sv48ptw_pkg::walk_type                     walk,
   input  logic [sv48ptw_pkg::PpnWidth-1:0]          root_ppn,
   output logic                                      emit,
   output sv48ptw_pkg::rsp_type                      rsp,
   output sv48ptw_pkg::walk_type                     walk_in
);
   import sv48ptw_pkg::*;

   logic [63:0]         pte;
   logic                v, r, w, x, a, d;
   logic [PpnWidth-1:0] ppn;
   logic [PpnWidth-1:0] mask;
   logic [PpnWidth-1:0] pa_ppn;
   logic [PpnWidth-1:0] va_vpn;
   logic                bad, leaf, perm_bad;
   logic [2:0]          fault;

   assign pte    = req.pte_word;
   assign v      = pte[0];
   assign r      = pte[1];
   assign w      = pte[2];
   assign x      = pte[3];
   assign a      = pte[6];
   assign d      = pte[7];
   assign ppn    = pte[53:10];
   assign mask   = super_mask(walk.level);
   assign va_vpn = {{(PpnWidth-36){1'b0}}, walk.vaddr[47:12]};
   assign pa_ppn = (ppn & ~mask) | (va_vpn & mask);

   assign bad      = !v || (!r && w) || (pte[63:54] != '0);
   assign leaf     = r || x;
   assign perm_bad = (walk.rights[RightRead] && !r) || (walk.rights[RightWrite] && !w) ||
                     (walk.rights[RightExec] && !x);

   always_comb begin
      if (bad) begin
         fault = FAULT_INVALID;
      end else if (perm_bad) begin
         fault = FAULT_PERMISSION;
      end else if ((ppn & mask) != '0) begin
         fault = FAULT_MISALIGNED;
      end else if (!a) begin
         fault = FAULT_ACCESSED;
      end else if (walk.rights[RightStore] && !d) begin
         fault = FAULT_DIRTY;
      end else begin
         fault = FAULT_NONE;
      end
   end

   always_comb begin
      emit    = 1'b0;
      rsp     = '0;
      walk_in = walk;
      case (req.operation)
         OP_START: begin
            emit = 1'b1;
            if (walk.busy) begin
               rsp.result_kind = KIND_REJECT;
               rsp.done_tag    = req.request_tag;
            end else begin
               walk_in.busy     = 1'b1;
               walk_in.level    = LEVEL_ROOT;
               walk_in.base_ppn = root_ppn;
               walk_in.vaddr    = req.virt_addr;
               walk_in.rights   = {req.store_access, req.need_exec, req.need_write,
                                   req.need_read};
               walk_in.tag      = req.request_tag;
               rsp.result_kind   = KIND_PTE_READ;
               rsp.pte_read_addr = pte_addr(root_ppn, req.virt_addr, LEVEL_ROOT);
            end
         end
         OP_FETCH_FAIL: begin
            if (walk.busy) begin
               emit = 1'b1;
               rsp.result_kind = KIND_DONE;
               rsp.done_tag    = walk.tag;
               rsp.fault_code  = FAULT_ACCESS;
               walk_in.busy    = 1'b0;
               walk_in.level   = LEVEL_ROOT;
            end
         end
         OP_PTE_DATA: begin
            if (walk.busy) begin
               emit = 1'b1;
               if (!bad && !leaf && walk.level != 2'd0) begin
                  // pointer: descend one level
                  walk_in.level    = walk.level - 2'd1;
                  walk_in.base_ppn = ppn;
                  rsp.result_kind   = KIND_PTE_READ;
                  rsp.pte_read_addr = pte_addr(ppn, walk.vaddr, walk.level - 2'd1);
               end else begin
                  rsp.result_kind = KIND_DONE;
                  rsp.done_tag    = walk.tag;
                  rsp.fault_code  = bad || !leaf ? FAULT_INVALID : fault;
                  if (!bad && leaf && fault == FAULT_NONE)
                     rsp.phys_addr = {pa_ppn, walk.vaddr[OffsetBits-1:0]};
                  walk_in.busy  = 1'b0;
                  walk_in.level = LEVEL_ROOT;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

endmodule

// ===== src/sv48_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// sv48_page_table_walker
// Single-walk Sv48 translation engine driven by request beats.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : request beats (start walk, PTE data, PTE fetch failure), valid/ready.
//   rsp_*  : result beats (PTE read request, walk complete, start rejected).
//   csr_*  : root table PPN, written whenever csr_write_enable is high; write
//            it only while no walk is in flight.
// Every request beat is handled in the cycle it is accepted; its result, if
// any, appears on rsp_* the next cycle. One beat per cycle is accepted as
// long as the result register is empty or being drained, so the rate is one
// beat per cycle, set by the single result register.
// A start while a walk is in flight is answered with a reject beat; PTE data
// or fetch failures with no walk in flight are dropped silently.
// When rsp_ready is low with a result pending, req_ready drops and the walk
// state holds until the result is taken.
// Reset (synchronous, active high) clears the walk, the pending result and
// the root PPN.
// ----------------------------------------------------------------------------
module sv48_page_table_walker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sv48ptw_pkg::req_type              req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sv48ptw_pkg::rsp_type              rsp_payload,
   input  logic                              csr_write_enable,
   input  logic [sv48ptw_pkg::PpnWidth-1:0]  csr_write_data
);
   import sv48ptw_pkg::*;

   logic [PpnWidth-1:0] root_ppn_ff;
   walk_type            walk_ff, walk_in;
   rsp_type             rsp_ff, step_rsp;
   logic                rsp_valid_ff;
   logic                emit;
   logic                accept;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   sv48ptw_step u_step (
      .req      (req_payload),
      .walk     (walk_ff),
      .root_ppn (root_ppn_ff),
      .emit     (emit),
      .rsp      (step_rsp),
      .walk_in  (walk_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ppn_ff <= '0;
      end else if (csr_write_enable) begin
         root_ppn_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= '{busy: 1'b0, level: LEVEL_ROOT, base_ppn: '0, vaddr: '0,
                      rights: '0, tag: '0};
      end else if (accept) begin
         walk_ff <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_ff <= step_rsp;
      end
   end

endmodule

// ===== verif/tb_sv48_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// tb_sv48_page_table_walker
// Self-checking bench for the Sv48 page-table walker. A driver feeds request
// beats from a backlog and a monitor scores every result beat against a
// walk predictor kept in the bench. Directed walks hit each fault and each
// ignored case; random walks then descend through pointers to leaves at every
// level, with rejects, reserved codes, fetch failures and broken PTEs mixed in.
// Root PPN is rewritten between phases once all results are in.
// ----------------------------------------------------------------------------
module tb_sv48_page_table_walker;
   timeunit 1ns;
   timeprecision 1ps;

   import sv48ptw_pkg::*;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int         CycleLimit  = 200_000;
   localparam int         PhaseBeats  = 500;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_payload;
   logic                csr_write_enable = 1'b0;
   logic [PpnWidth-1:0] csr_write_data = '0;

   sv48_page_table_walker DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // bench-side walk state
   logic [PpnWidth-1:0] root_ppn = '0;
   logic                walk_busy = 1'b0;
   logic [1:0]          walk_lvl = LEVEL_ROOT;
   logic [PpnWidth-1:0] table_ppn = '0;
   logic [VaWidth-1:0]  held_va = '0;
   logic                need_rd = 1'b0, need_wr = 1'b0, need_ex = 1'b0, store_acc = 1'b0;
   logic [TagWidth-1:0] held_tag = '0;

   req_type req_backlog[$];
   rsp_type rsp_due[$];
   rsp_type want_rsp;
   int      pushed_count = 0;
   int      accepted_count = 0;
   int      errors = 0;
   int      cycles = 0;
   logic    req_fired = 1'b0;
   logic    steady = 1'b0;

   // ---------------------------------------------------------------- predictor
   task automatic request_pte();
      rsp_type    r;
      logic [8:0] vpn;
      vpn = 9'(held_va >> (OffsetBits + VpnBits * walk_lvl));
      r = '0;
      r.result_kind   = KIND_PTE_READ;
      r.pte_read_addr = {table_ppn, vpn, 3'b000};
      rsp_due.push_back(r);
   endtask

   task automatic end_walk(input logic [2:0] fault, input logic [PaWidth-1:0] pa);
      rsp_type r;
      r = '0;
      r.result_kind = KIND_DONE;
      r.done_tag    = held_tag;
      r.fault_code  = fault;
      r.phys_addr   = (fault == FAULT_NONE) ? pa : '0;
      rsp_due.push_back(r);
      walk_busy = 1'b0;
      walk_lvl  = LEVEL_ROOT;
   endtask

   task automatic advance_walk(input req_type b);
      rsp_type             r;
      logic [63:0]         pte;
      logic [PpnWidth-1:0] ppn, low, va_vpn;
      pte    = b.pte_word;
      ppn    = pte[53:10];
      low    = (44'd1 << (VpnBits * walk_lvl)) - 44'd1;
      va_vpn = {8'd0, held_va[47:12]};
      if (b.operation == OP_START) begin
         if (walk_busy) begin
            r = '0;
            r.result_kind = KIND_REJECT;
            r.done_tag    = b.request_tag;
            rsp_due.push_back(r);
         end else begin
            walk_busy = 1'b1;
            walk_lvl  = LEVEL_ROOT;
            table_ppn = root_ppn;
            held_va   = b.virt_addr;
            need_rd   = b.need_read;
            need_wr   = b.need_write;
            need_ex   = b.need_exec;
            store_acc = b.store_access;
            held_tag  = b.request_tag;
            request_pte();
         end
      end else if (!walk_busy || b.operation == OP_RESERVED) begin
         // dropped, no beat out
      end else if (b.operation == OP_FETCH_FAIL) begin
         end_walk(FAULT_ACCESS, '0);
      end else if (!pte[0] || (!pte[1] && pte[2]) || pte[63:54] != '0) begin
         end_walk(FAULT_INVALID, '0);
      end else if (!pte[1] && !pte[3]) begin
         if (walk_lvl == 2'd0) begin
            end_walk(FAULT_INVALID, '0);
         end else begin
            walk_lvl  = walk_lvl - 2'd1;
            table_ppn = ppn;
            request_pte();
         end
      end else if ((need_rd && !pte[1]) || (need_wr && !pte[2]) || (need_ex && !pte[3])) begin
         end_walk(FAULT_PERMISSION, '0);
      end else if (walk_lvl != 2'd0 && (ppn & low) != '0) begin
         end_walk(FAULT_MISALIGNED, '0);
      end else if (!pte[6]) begin
         end_walk(FAULT_ACCESSED, '0);
      end else if (store_acc && !pte[7]) begin
         end_walk(FAULT_DIRTY, '0);
      end else begin
         end_walk(FAULT_NONE, {(ppn & ~low) | (va_vpn & low), held_va[11:0]});
      end
   endtask

   // ---------------------------------------------------------------- driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
            req_payload <= req_backlog.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && (steady || $urandom_range(99) >= 33);
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && req_ready;
         // score the result first: a request taken at this edge answers later
         if (rsp_valid && rsp_ready) begin
            if (rsp_due.size() == 0) begin
               $error("rsp beat with no result outstanding: %p", rsp_payload);
               errors++;
            end else begin
               want_rsp = rsp_due.pop_front();
               if (rsp_payload.result_kind !== want_rsp.result_kind) begin
                  $error("result_kind: expected %0d, got %0d",
                         want_rsp.result_kind, rsp_payload.result_kind);
                  errors++;
               end
               if (rsp_payload.pte_read_addr !== want_rsp.pte_read_addr) begin
                  $error("pte_read_addr: expected %h, got %h",
                         want_rsp.pte_read_addr, rsp_payload.pte_read_addr);
                  errors++;
               end
               if (rsp_payload.done_tag !== want_rsp.done_tag) begin
                  $error("done_tag: expected %h, got %h",
                         want_rsp.done_tag, rsp_payload.done_tag);
                  errors++;
               end
               if (rsp_payload.fault_code !== want_rsp.fault_code) begin
                  $error("fault_code: expected %0d, got %0d",
                         want_rsp.fault_code, rsp_payload.fault_code);
                  errors++;
               end
               if (rsp_payload.phys_addr !== want_rsp.phys_addr) begin
                  $error("phys_addr: expected %h, got %h",
                         want_rsp.phys_addr, rsp_payload.phys_addr);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            accepted_count++;
            advance_walk(req_payload);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("** sv48_page_table_walker: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic req_type rand_beat(input logic [1:0] op);
      req_type b;
      b.operation    = op;
      b.virt_addr    = {16'($urandom), $urandom};
      b.need_read    = 1'($urandom);
      b.need_write   = 1'($urandom);
      b.need_exec    = 1'($urandom);
      b.store_access = 1'($urandom);
      b.request_tag  = 8'($urandom);
      b.pte_word     = {$urandom, $urandom};
      return b;
   endfunction

   // rights: {store, exec, write, read}
   function automatic req_type start_beat(input logic [VaWidth-1:0] va,
                                          input logic [3:0] rights,
                                          input logic [TagWidth-1:0] tag);
      req_type b;
      b = rand_beat(OP_START);
      b.virt_addr    = va;
      b.need_read    = rights[RightRead];
      b.need_write   = rights[RightWrite];
      b.need_exec    = rights[RightExec];
      b.store_access = rights[RightStore];
      b.request_tag  = tag;
      return b;
   endfunction

   function automatic req_type data_beat(input logic [63:0] pte);
      req_type b;
      b = rand_beat(OP_PTE_DATA);
      b.pte_word = pte;
      return b;
   endfunction

   // V set, R/W/X clear; U, G, A, D and RSW left random
   function automatic logic [63:0] pointer_pte(input logic [PpnWidth-1:0] ppn);
      logic [63:0] p;
      p = {$urandom, $urandom};
      p[63:54] = '0;
      p[53:10] = ppn;
      p[3:0]   = 4'b0001;
      return p;
   endfunction

   // flags: {D, A, G, U, X, W, R, V}; RSW set to show it is ignored
   function automatic logic [63:0] leaf_pte(input logic [PpnWidth-1:0] ppn,
                                            input logic [7:0] flags);
      return {10'd0, ppn, 2'b11, flags};
   endfunction

   task automatic queue_beat(input req_type b);
      req_backlog.push_back(b);
      pushed_count++;
   endtask

   task automatic queue_walk();
      req_type             b;
      int                  leaf_lvl, lvl, roll;
      logic [63:0]         pte;
      logic [PpnWidth-1:0] ppn;
      logic                r, w, x, bent;
      b = rand_beat(OP_START);
      queue_beat(b);
      leaf_lvl = $urandom_range(3, 0);
      for (lvl = 3; lvl > leaf_lvl; lvl--) begin
         roll = $urandom_range(99);
         if (roll < 5) begin
            queue_beat(rand_beat(OP_START));
         end else if (roll < 8) begin
            queue_beat(rand_beat(OP_RESERVED));
         end else if (roll < 11) begin
            queue_beat(rand_beat(OP_FETCH_FAIL));
            return;
         end else if (roll < 15) begin
            // garbage PTE; the failure beat closes the walk if it survived
            queue_beat(rand_beat(OP_PTE_DATA));
            queue_beat(rand_beat(OP_FETCH_FAIL));
            return;
         end
         queue_beat(data_beat(pointer_pte({12'($urandom), $urandom})));
      end
      ppn = {12'($urandom), $urandom};
      if ($urandom_range(9) != 0)
         ppn = ppn & ~((44'd1 << (VpnBits * leaf_lvl)) - 44'd1);
      r = b.need_read | 1'($urandom);
      w = b.need_write | 1'($urandom);
      x = b.need_exec | 1'($urandom);
      if (w)
         r = 1'b1;
      if (!r && !x)
         r = 1'b1;
      pte = pointer_pte(ppn);
      pte[3:1] = {x, w, r};
      pte[6]   = ($urandom_range(9) != 0);
      pte[7]   = ($urandom_range(9) != 0);
      if ($urandom_range(19) == 0)
         pte[63:54] = 10'($urandom);
      bent = ($urandom_range(9) == 0);
      if (bent)
         pte[$urandom_range(3, 0)] ^= 1'b1;
      queue_beat(data_beat(pte));
      // a bent leaf may turn into a pointer and leave the walk open
      if (bent)
         queue_beat(rand_beat(OP_FETCH_FAIL));
   endtask

   task automatic run_random(input int count);
      int target;
      target = pushed_count + count;
      while (pushed_count < target) begin
         if ($urandom_range(19) == 0)
            queue_beat(rand_beat(2'($urandom_range(3, 1))));
         else
            queue_walk();
      end
   endtask

   task automatic wait_drained();
      while (accepted_count != pushed_count || rsp_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // hold off until every result is in and no walk is left open
   task automatic settle();
      wait_drained();
      while (walk_busy) begin
         queue_beat(rand_beat(OP_FETCH_FAIL));
         wait_drained();
      end
   endtask

   task automatic write_root(input logic [PpnWidth-1:0] ppn);
      csr_write_enable <= 1'b1;
      csr_write_data   <= ppn;
      root_ppn = ppn;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_root('1);
      // full descent to a pointer at the last level, with a reject and noise
      queue_beat(start_beat('1, 4'b0000, 8'hFF));
      queue_beat(start_beat('0, 4'b1111, 8'h00));
      queue_beat(rand_beat(OP_RESERVED));
      queue_beat(data_beat(pointer_pte('1)));
      queue_beat(data_beat(pointer_pte('0)));
      queue_beat(data_beat(pointer_pte(44'hA5A_5A5A_5A5A)));
      queue_beat(data_beat(pointer_pte(44'h123_4567_89AB)));
      // stray beats with no walk open
      queue_beat(rand_beat(OP_PTE_DATA));
      queue_beat(rand_beat(OP_FETCH_FAIL));
      // aligned top-level leaf
      queue_beat(start_beat('0, 4'b0111, 8'h01));
      queue_beat(data_beat(leaf_pte(44'hFFF_F800_0000, 8'hCF)));
      // misaligned superpage
      queue_beat(start_beat('1, 4'b1000, 8'h80));
      queue_beat(data_beat(leaf_pte(44'h000_0000_0001, 8'hCF)));
      // missing write right
      queue_beat(start_beat(48'h7654_3210_FEDC, 4'b0010, 8'h02));
      queue_beat(data_beat(leaf_pte('0, 8'hC3)));
      // accessed clear, then dirty clear on a store
      queue_beat(start_beat(48'h8000_0000_1000, 4'b0000, 8'h03));
      queue_beat(data_beat(leaf_pte('0, 8'h8B)));
      queue_beat(start_beat(48'h0000_4020_1ABC, 4'b1000, 8'h04));
      queue_beat(data_beat(leaf_pte('0, 8'h43)));
      // write without read, reserved bits set, valid clear
      queue_beat(start_beat(48'h1111_2222_3333, 4'b0000, 8'h05));
      queue_beat(data_beat(leaf_pte('0, 8'hC5)));
      queue_beat(start_beat(48'h4444_5555_6666, 4'b0000, 8'h06));
      queue_beat(data_beat(leaf_pte('0, 8'hCF) | 64'h8000_0000_0000_0000));
      queue_beat(start_beat(48'h7777_8888_9999, 4'b0000, 8'h07));
      queue_beat(data_beat(leaf_pte('1, 8'hCE)));
      // fetch failure
      queue_beat(start_beat(48'hAAAA_BBBB_CCCC, 4'b0001, 8'h08));
      queue_beat(rand_beat(OP_FETCH_FAIL));
      settle();

      write_root('0);
      run_random(PhaseBeats);
      settle();

      write_root({12'($urandom), $urandom});
      steady = 1'b1;
      run_random(PhaseBeats);
      settle();
      steady = 1'b0;

      write_root({12'($urandom), $urandom});
      run_random(PhaseBeats);
      settle();

      if (errors == 0 && rsp_due.size() == 0)
         $display("** sv48_page_table_walker: PASSED **");
      else
         $display("** sv48_page_table_walker: FAILED **");
      $finish;
   end

endmodule
